>>> rtl/tpsb_pkg.sv
`default_nettype none

package tpsb_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_T0_MODE = 3'd0;
	localparam logic [2:0] CFG_T1_MODE = 3'd1;
	localparam logic [2:0] CFG_SER_MODE = 3'd2;
	localparam logic [2:0] CFG_GIE = 3'd3;
	localparam logic [2:0] CFG_T0_IE = 3'd4;
	localparam logic [2:0] CFG_T1_IE = 3'd5;
	localparam logic [2:0] CFG_T0_RUN = 3'd6;
	localparam logic [2:0] CFG_T1_RUN = 3'd7;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// software write targets
	localparam logic [2:0] TGT_TL0 = 3'd0;
	localparam logic [2:0] TGT_TH0 = 3'd1;
	localparam logic [2:0] TGT_TL1 = 3'd2;
	localparam logic [2:0] TGT_TH1 = 3'd3;
	localparam logic [2:0] TGT_SBUF = 3'd4;
	localparam logic [2:0] TGT_FLAGS = 3'd5;

	// supported modes
	localparam logic [1:0] T0_MODE_13BIT = 2'd0;
	localparam logic [1:0] T0_MODE_16BIT = 2'd1;
	localparam logic [1:0] T1_MODE_RELOAD = 2'd2;
	localparam logic [1:0] SER_MODE_1 = 2'd1;

	// low byte limit in thirteen-bit mode
	localparam logic [7:0] LOW13_LIMIT = 8'h1F;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_T0_MODE = 2'd1;
	localparam logic [1:0] ERR_T1_MODE = 2'd2;
	localparam logic [1:0] ERR_SER_MODE = 2'd3;

	typedef struct packed {
		logic [1:0] timer0_mode;
		logic [1:0] timer1_mode;
		logic [1:0] sio_mode;
		logic       gie;
		logic       t0_ie;
		logic       t1_ie;
		logic       t0_run;
		logic       t1_run;
	} cfg_t;

	typedef struct packed {
		logic [7:0] tl0;
		logic [7:0] th0;
		logic [7:0] tl1;
		logic [7:0] th1;
		logic       tf0;
		logic       tf1;
		logic       ti;
		logic       tx_pending;
		logic [7:0] tx_data;
	} state_t;

	typedef struct packed {
		logic       kind;
		logic [2:0] target;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic [15:0] count0;
		logic [15:0] count1;
		logic        tf0;
		logic        tf1;
		logic        ti;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [1:0]  error_code;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/tpsb_cfg.sv
`default_nettype none

module tpsb_cfg
	import tpsb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       we,
	input  wire logic [2:0] index,
	input  wire logic [1:0] data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (we) begin
			unique case (index)
				CFG_T0_MODE:  cfg_q.timer0_mode <= data;
				CFG_T1_MODE:  cfg_q.timer1_mode <= data;
				CFG_SER_MODE: cfg_q.sio_mode <= data;
				CFG_GIE:      cfg_q.gie <= data[0];
				CFG_T0_IE:    cfg_q.t0_ie <= data[0];
				CFG_T1_IE:    cfg_q.t1_ie <= data[0];
				CFG_T0_RUN:   cfg_q.t0_run <= data[0];
				CFG_T1_RUN:   cfg_q.t1_run <= data[0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/tpsb_step.sv
`default_nettype none

module tpsb_step
	import tpsb_pkg::*;
(
	input  cfg_t    cfg,
	input  state_t  cur,
	input  item_t   item,
	output state_t  nxt,
	output result_t res
);

	logic [7:0] tl0_inc;
	logic [7:0] th0_inc;
	logic [7:0] tl1_inc;
	logic       carry0;
	logic [1:0] err;
	logic       sent;
	logic [7:0] sent_byte;

	assign tl0_inc = cur.tl0 + 8'd1;
	assign th0_inc = cur.th0 + 8'd1;
	assign tl1_inc = cur.tl1 + 8'd1;

	always_comb begin
		nxt = cur;
		err = ERR_NONE;
		sent = 1'b0;
		sent_byte = 8'h00;
		carry0 = 1'b0;
		if (item.kind == KIND_WRITE) begin
			case (item.target)
				TGT_TL0:   nxt.tl0 = item.write_data;
				TGT_TH0:   nxt.th0 = item.write_data;
				TGT_TL1:   nxt.tl1 = item.write_data;
				TGT_TH1:   nxt.th1 = item.write_data;
				TGT_SBUF: begin
					nxt.tx_data = item.write_data;
					nxt.tx_pending = 1'b1;
				end
				TGT_FLAGS: begin
					nxt.tf0 = item.write_data[0];
					nxt.tf1 = item.write_data[1];
					nxt.ti = item.write_data[2];
				end
				default: ;
			endcase
		end else begin
			if (cfg.t0_run) begin
				if (cfg.timer0_mode == T0_MODE_13BIT) begin
					// 8-bit increment, then clip above 31; 255 wraps without carry
					if (tl0_inc > LOW13_LIMIT) begin
						nxt.tl0 = 8'h00;
						carry0 = 1'b1;
					end else begin
						nxt.tl0 = tl0_inc;
					end
				end else if (cfg.timer0_mode == T0_MODE_16BIT) begin
					nxt.tl0 = tl0_inc;
					carry0 = (tl0_inc == 8'h00);
				end else begin
					err = ERR_T0_MODE;
				end
				if (carry0) begin
					nxt.th0 = th0_inc;
					if (th0_inc == 8'h00 && cfg.gie && cfg.t0_ie)
						nxt.tf0 = 1'b1;
				end
			end
			if (cfg.t1_run) begin
				if (cfg.timer1_mode == T1_MODE_RELOAD) begin
					nxt.tl1 = tl1_inc;
					if (tl1_inc == 8'h00) begin
						nxt.tl1 = cur.th1;
						if (cfg.gie && cfg.t1_ie)
							nxt.tf1 = 1'b1;
						if (cfg.sio_mode == SER_MODE_1) begin
							if (cur.tx_pending) begin
								nxt.tx_pending = 1'b0;
								nxt.ti = 1'b1;
								sent = 1'b1;
								sent_byte = cur.tx_data;
							end
						end else if (err == ERR_NONE) begin
							err = ERR_SER_MODE;
						end
					end
				end else if (err == ERR_NONE) begin
					err = ERR_T1_MODE;
				end
			end
		end
	end

	always_comb begin
		res.count0 = {nxt.th0, nxt.tl0};
		res.count1 = {nxt.th1, nxt.tl1};
		res.tf0 = nxt.tf0;
		res.tf1 = nxt.tf1;
		res.ti = nxt.ti;
		res.tx_valid = sent;
		res.tx_byte = sent_byte;
		res.error_code = err;
	end

endmodule

`default_nettype wire

>>> rtl/timer_pair_with_serial_baud_tick.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    kind, target, write_data
// out       out_valid / out_ready  count0, count1, overflow0_flag, overflow1_flag,
//                                  transmit_flag, tx_valid, tx_byte, error_code
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; each passes stage 1, then the result register.
// Stage 1 holds the accepted item; the timer state and the result register update
// together as it moves on, so each item sees the state its predecessor left.
// A stalled result holds stage 1; in_ready stays high while stage 1 can drain.
// arst_n clears the timers, flags, pending byte and configuration to zero.
// cfg_ready is always high; a write lands at the edge of its transfer.
`default_nettype none

module timer_pair_with_serial_baud_tick
	import tpsb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [2:0]  target,
	input  wire logic [7:0]  write_data,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      count0,
	output logic [15:0]      count1,
	output logic             overflow0_flag,
	output logic             overflow1_flag,
	output logic             transmit_flag,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic [1:0]       error_code,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [1:0]  cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	logic    adv;

	// configuration write channel: never stalls
	assign cfg_ready = 1'b1;

	tpsb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_valid),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// stage 1 moves on when the result slot is free or being emptied
	assign adv = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= '{kind: kind, target: target, write_data: write_data};
	end

	// next state and result from the held item
	tpsb_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv)
				state_q <= state_nxt;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nxt;
	end

	assign out_valid = valid_s2;
	assign count0 = res_s2.count0;
	assign count1 = res_s2.count1;
	assign overflow0_flag = res_s2.tf0;
	assign overflow1_flag = res_s2.tf1;
	assign transmit_flag = res_s2.ti;
	assign tx_valid = res_s2.tx_valid;
	assign tx_byte = res_s2.tx_byte;
	assign error_code = res_s2.error_code;

	// a sent byte always leaves TI set
	a_tx_sets_ti: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.tx_valid |-> res_s2.ti)
		else $error("tx without TI");

	// nothing sent means a zero byte
	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.tx_valid |-> res_s2.tx_byte == 8'h00)
		else $error("stray tx byte");

	// a serial mode error never goes with a transmission
	a_ser_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.error_code == ERR_SER_MODE |-> !res_s2.tx_valid)
		else $error("tx under bad serial mode");

	// a transmission drains the pending byte
	a_pending_clr: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_nxt.tx_valid |=> !state_q.tx_pending)
		else $error("pending byte not cleared");

	// an empty stage 1 always takes input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("stage 1 empty but not ready");

endmodule

`default_nettype wire

>>> tb/tb_timer_pair_with_serial_baud_tick.sv
`default_nettype none

module tb_timer_pair_with_serial_baud_tick;
	import tpsb_pkg::*;

	// unsupported mode encodings, used to provoke the error codes
	localparam logic [1:0] T0_MODE_BAD_A = 2'd2;
	localparam logic [1:0] T0_MODE_BAD_B = 2'd3;
	localparam logic [1:0] T1_MODE_BAD_A = 2'd0;
	localparam logic [1:0] T1_MODE_BAD_B = 2'd1;
	localparam logic [1:0] T1_MODE_BAD_C = 2'd3;
	localparam logic [1:0] SER_MODE_0 = 2'd0;
	localparam logic [1:0] SER_MODE_2 = 2'd2;
	localparam logic [1:0] SER_MODE_3 = 2'd3;

	localparam int NUM_REGS = 8;
	localparam int QUIET_LIMIT = 1000;	// cycles without any transfer
	localparam int DRAIN_CYCLES = 10;	// extra wait after the last result, beyond the pipeline latency

	// Shadow copy of the timer pair: register settings, counters and flags.
	// Every accepted item advances it and leaves one expected snapshot behind.
	class timer_shadow;
		cfg_t regs;
		state_t st;
		result_t due_snapshots[$];
		int mismatches;
		int items_seen;
		int results_seen;
		int bytes_sent;
		int tf0_raised;
		int tf1_raised;

		function new();
			regs = '0;
			st = '0;
			mismatches = 0;
			items_seen = 0;
			results_seen = 0;
			bytes_sent = 0;
			tf0_raised = 0;
			tf1_raised = 0;
		endfunction

		// one-bit registers keep only bit 0 of the written data
		function void set_register(logic [2:0] idx, logic [1:0] val);
			case (idx)
				CFG_T0_MODE: regs.timer0_mode = val;
				CFG_T1_MODE: regs.timer1_mode = val;
				CFG_SER_MODE: regs.sio_mode = val;
				CFG_GIE: regs.gie = val[0];
				CFG_T0_IE: regs.t0_ie = val[0];
				CFG_T1_IE: regs.t1_ie = val[0];
				CFG_T0_RUN: regs.t0_run = val[0];
				CFG_T1_RUN: regs.t1_run = val[0];
				default: ;
			endcase
		endfunction

		function void note_item(item_t it);
			result_t r;
			logic carry;
			r = '0;
			carry = 1'b0;
			items_seen++;
			if (it.kind == KIND_WRITE) begin
				case (it.target)
					TGT_TL0: st.tl0 = it.write_data;
					TGT_TH0: st.th0 = it.write_data;
					TGT_TL1: st.tl1 = it.write_data;
					TGT_TH1: st.th1 = it.write_data;
					TGT_SBUF: begin
						// a second write simply replaces the waiting byte
						st.tx_data = it.write_data;
						st.tx_pending = 1'b1;
					end
					TGT_FLAGS: {st.ti, st.tf1, st.tf0} = it.write_data[2:0];
					default: ;
				endcase
			end else begin
				if (regs.t0_run) begin
					if (regs.timer0_mode == T0_MODE_13BIT) begin
						// 8-bit increment first: 255 wraps to 0 with no carry
						st.tl0 = st.tl0 + 8'd1;
						if (st.tl0 > LOW13_LIMIT) begin
							st.tl0 = 8'h00;
							carry = 1'b1;
						end
					end else if (regs.timer0_mode == T0_MODE_16BIT) begin
						st.tl0 = st.tl0 + 8'd1;
						carry = (st.tl0 == 8'h00);
					end else begin
						r.error_code = ERR_T0_MODE;
					end
					if (carry) begin
						st.th0 = st.th0 + 8'd1;
						if (st.th0 == 8'h00 && regs.gie && regs.t0_ie) begin
							st.tf0 = 1'b1;
							tf0_raised++;
						end
					end
				end
				if (regs.t1_run) begin
					if (regs.timer1_mode == T1_MODE_RELOAD) begin
						st.tl1 = st.tl1 + 8'd1;
						if (st.tl1 == 8'h00) begin
							st.tl1 = st.th1;
							if (regs.gie && regs.t1_ie) begin
								st.tf1 = 1'b1;
								tf1_raised++;
							end
							if (regs.sio_mode == SER_MODE_1) begin
								if (st.tx_pending) begin
									st.tx_pending = 1'b0;
									st.ti = 1'b1;
									r.tx_valid = 1'b1;
									r.tx_byte = st.tx_data;
									bytes_sent++;
								end
							end else if (r.error_code == ERR_NONE) begin
								r.error_code = ERR_SER_MODE;
							end
						end
					end else if (r.error_code == ERR_NONE) begin
						r.error_code = ERR_T1_MODE;
					end
				end
			end
			r.count0 = {st.th0, st.tl0};
			r.count1 = {st.th1, st.tl1};
			r.tf0 = st.tf0;
			r.tf1 = st.tf1;
			r.ti = st.ti;
			due_snapshots.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_snapshots.size() == 0) begin
				$error("result transfer with no item outstanding");
				mismatches++;
				return;
			end
			want = due_snapshots.pop_front();
			results_seen++;
			compare_field("count0", want.count0, got.count0);
			compare_field("count1", want.count1, got.count1);
			compare_field("overflow0_flag", 16'(want.tf0), 16'(got.tf0));
			compare_field("overflow1_flag", 16'(want.tf1), 16'(got.tf1));
			compare_field("transmit_flag", 16'(want.ti), 16'(got.ti));
			compare_field("tx_valid", 16'(want.tx_valid), 16'(got.tx_valid));
			compare_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
			compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [2:0] target;
	logic [7:0] write_data;
	logic out_valid;
	logic out_ready;
	logic [15:0] count0;
	logic [15:0] count1;
	logic overflow0_flag;
	logic overflow1_flag;
	logic transmit_flag;
	logic tx_valid;
	logic [7:0] tx_byte;
	logic [1:0] error_code;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [1:0] cfg_data;

	timer_shadow shadow;
	item_t feed_q[$];	// items waiting to be offered to the block
	int send_idle_pct;	// chance per item slot that the sender holds off
	int recv_stall_pct;	// chance per cycle that out_ready is low
	int settings_used;
	int directed_items;

	timer_pair_with_serial_baud_tick dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.target(target),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.count0(count0),
		.count1(count1),
		.overflow0_flag(overflow0_flag),
		.overflow1_flag(overflow1_flag),
		.transmit_flag(transmit_flag),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.error_code(error_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ticks ignore target and data, so those carry random bits to catch any leak.
	function automatic item_t tick_item();
		item_t it;
		it.kind = KIND_TICK;
		it.target = 3'($urandom_range(0, 7));
		it.write_data = 8'($urandom);
		return it;
	endfunction

	function automatic item_t write_item(logic [2:0] tgt, logic [7:0] data);
		item_t it;
		it.kind = KIND_WRITE;
		it.target = tgt;
		it.write_data = data;
		return it;
	endfunction

	// Mostly well-formed sequences: load a counter just short of overflow, queue a
	// serial byte, then tick through the edge. The rest is stray writes and flag pokes.
	task automatic queue_random_traffic(input int count);
		int ignored;
		int burst;
		logic [2:0] tgt;
		ignored = 0;
		while (feed_q.size() - ignored < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					if ($urandom_range(0, 1))
						feed_q.push_back(write_item(TGT_TH1, 8'($urandom_range(240, 255))));
					feed_q.push_back(write_item(TGT_TL1, 8'($urandom_range(250, 255))));
					if ($urandom_range(0, 2) != 0)
						feed_q.push_back(write_item(TGT_SBUF, 8'($urandom)));
				end
				3, 4: begin
					feed_q.push_back(write_item(TGT_TH0,
						$urandom_range(0, 3) != 0 ? 8'hFF : 8'($urandom)));
					// near the 13-bit low limit or near the 8-bit wrap
					feed_q.push_back(write_item(TGT_TL0, $urandom_range(0, 1) ?
						8'($urandom_range(28, 31)) : 8'($urandom_range(252, 255))));
				end
				5: feed_q.push_back(write_item(TGT_FLAGS,
					$urandom_range(0, 1) ? 8'h00 : 8'($urandom)));
				6: begin
					tgt = 3'($urandom_range(0, 7));
					if (tgt > TGT_FLAGS)
						ignored++;
					feed_q.push_back(write_item(tgt, 8'($urandom)));
				end
				default: begin
					burst = $urandom_range(1, 12);
					repeat (burst) feed_q.push_back(tick_item());
				end
			endcase
		end
	endtask

	// Offer every queued item; valid stays up with the payload held until the transfer.
	task automatic drive_items();
		item_t it;
		while (feed_q.size() != 0) begin
			if ($urandom_range(0, 99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end else begin
				it = feed_q.pop_front();
				in_valid <= 1'b1;
				kind <= it.kind;
				target <= it.target;
				write_data <= it.write_data;
				do @(posedge clk); while (!in_ready);
				shadow.note_item(it);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Every item yields a result, so an empty expectation queue means the block is idle.
	task automatic wait_idle();
		while (shadow.due_snapshots.size() != 0) @(posedge clk);
	endtask

	// Writes all eight registers; one-bit registers get a random upper data bit.
	task automatic apply_settings(input cfg_t c);
		logic [1:0] vals[NUM_REGS];
		vals[CFG_T0_MODE] = c.timer0_mode;
		vals[CFG_T1_MODE] = c.timer1_mode;
		vals[CFG_SER_MODE] = c.sio_mode;
		vals[CFG_GIE] = {1'($urandom_range(0, 1)), c.gie};
		vals[CFG_T0_IE] = {1'($urandom_range(0, 1)), c.t0_ie};
		vals[CFG_T1_IE] = {1'($urandom_range(0, 1)), c.t1_ie};
		vals[CFG_T0_RUN] = {1'($urandom_range(0, 1)), c.t0_run};
		vals[CFG_T1_RUN] = {1'($urandom_range(0, 1)), c.t1_run};
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			shadow.set_register(3'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_phase(input cfg_t c);
		wait_idle();
		apply_settings(c);
		drive_items();
	endtask

	// Result side: sample at the edge, then decide the next cycle's ready.
	initial begin
		result_t seen;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				seen = {count0, count1, overflow0_flag, overflow1_flag, transmit_flag,
					tx_valid, tx_byte, error_code};
				shadow.check_result(seen);
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	initial begin
		cfg_t random_settings[9];
		cfg_t all_on;
		in_valid = 1'b0;
		kind = KIND_TICK;
		target = TGT_TL0;
		write_data = 8'h00;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_T0_MODE;
		cfg_data = 2'd0;
		arst_n = 1'b0;
		shadow = new();
		settings_used = 0;
		send_idle_pct = 36;
		recv_stall_pct = 67;
		all_on = '{T0_MODE_13BIT, T1_MODE_RELOAD, SER_MODE_1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// Reset settings: nothing runs, a tick changes nothing, target 7 is dropped.
		feed_q.push_back(tick_item());
		feed_q.push_back(write_item(3'd7, 8'hFF));
		drive_items();

		// Everything enabled. 13-bit carry into a full high byte raises TF0; timer 1
		// overflow reloads from TH1, raises TF1 and sends the waiting byte.
		feed_q.push_back(write_item(TGT_TL0, LOW13_LIMIT));
		feed_q.push_back(write_item(TGT_TH0, 8'hFF));
		feed_q.push_back(write_item(TGT_TH1, 8'hA5));
		feed_q.push_back(write_item(TGT_TL1, 8'hFF));
		feed_q.push_back(write_item(TGT_SBUF, 8'h3C));
		feed_q.push_back(tick_item());
		// low byte of 255 in 13-bit mode wraps without a carry
		feed_q.push_back(write_item(TGT_TL0, 8'hFF));
		feed_q.push_back(tick_item());
		// serial buffer overwritten while pending: only the later byte goes out
		feed_q.push_back(write_item(TGT_SBUF, 8'h11));
		feed_q.push_back(write_item(TGT_SBUF, 8'hEE));
		feed_q.push_back(write_item(TGT_TL1, 8'hFF));
		feed_q.push_back(tick_item());
		// flag writes use bits 2..0 only; target 6 is dropped
		feed_q.push_back(write_item(TGT_FLAGS, 8'hF8));
		feed_q.push_back(write_item(TGT_FLAGS, 8'h07));
		feed_q.push_back(write_item(3'd6, 8'hA5));
		run_phase(all_on);

		// Both timer modes bad and serial mode bad at once: lowest code wins.
		feed_q.push_back(tick_item());
		run_phase('{T0_MODE_BAD_B, T1_MODE_BAD_B, SER_MODE_0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1});

		// Global enable off: overflows leave the flags alone; serial mode 2 gives
		// the serial error with the byte left pending.
		feed_q.push_back(write_item(TGT_FLAGS, 8'h00));
		feed_q.push_back(write_item(TGT_TH0, 8'hFF));
		feed_q.push_back(write_item(TGT_TL0, 8'hFF));
		feed_q.push_back(write_item(TGT_TL1, 8'hFF));
		feed_q.push_back(write_item(TGT_SBUF, 8'h5A));
		feed_q.push_back(tick_item());
		run_phase('{T0_MODE_16BIT, T1_MODE_RELOAD, SER_MODE_2, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1});
		directed_items = shadow.items_seen;

		// --- random part: nine settings, three per pacing regime ---
		random_settings[0] = all_on;
		random_settings[1] = '{T0_MODE_16BIT, T1_MODE_RELOAD, SER_MODE_1,
			1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		random_settings[2] = '{T0_MODE_13BIT, T1_MODE_RELOAD, SER_MODE_1,
			1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
		random_settings[3] = '{T0_MODE_16BIT, T1_MODE_RELOAD, SER_MODE_0,
			1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
		random_settings[4] = '{T0_MODE_BAD_A, T1_MODE_BAD_A, SER_MODE_1,
			1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		random_settings[5] = '{T0_MODE_BAD_B, T1_MODE_BAD_C, SER_MODE_1,
			1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		random_settings[6] = '{T0_MODE_16BIT, T1_MODE_RELOAD, SER_MODE_3,
			1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		random_settings[7] = '{T0_MODE_13BIT, T1_MODE_RELOAD, SER_MODE_1,
			1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
		random_settings[8] = '{T0_MODE_BAD_B, T1_MODE_BAD_C, SER_MODE_3,
			1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

		for (int p = 0; p < 9; p++) begin
			if (p == 3) begin
				send_idle_pct = 67;
				recv_stall_pct = 36;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			queue_random_traffic(110);
			run_phase(random_settings[p]);
		end

		// Settle back to all-zero settings, the reset value of every configuration register.
		queue_random_traffic(20);
		run_phase('0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items (%0d directed) under %0d register settings, three pacing regimes.",
			shadow.items_seen, directed_items, settings_used);
		$display("Compared %0d results; %0d serial bytes sent, TF0 raised %0d times, TF1 %0d times.",
			shadow.results_seen, shadow.bytes_sent, shadow.tf0_raised, shadow.tf1_raised);
		if (shadow.mismatches == 0 && shadow.due_snapshots.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (shadow.due_snapshots.size() != 0)
				$error("%0d expected results never arrived", shadow.due_snapshots.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/tpsb_pkg.sv
rtl/tpsb_cfg.sv
rtl/tpsb_step.sv
rtl/timer_pair_with_serial_baud_tick.sv
tb/tb_timer_pair_with_serial_baud_tick.sv
